// ===== rtl/ola_pkg.sv =====
// Shared types and sizing constants for the overlap layer assigner.
// No dependencies; every other file in this block imports this package.
package ola_pkg;

	// Storage sizing: number of layers and rectangles per layer.
	localparam int MAX_LAYERS  = 16;
	localparam int LAYER_SLOTS = 16;

	// Derived widths.
	localparam int LAYER_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int SLOT_AW  = (LAYER_SLOTS > 1) ? $clog2(LAYER_SLOTS) : 1;
	localparam int NEED_W   = $clog2(MAX_LAYERS + 1);
	localparam int FILL_W   = $clog2(LAYER_SLOTS + 1);
	localparam int CNT_MAX  = (MAX_LAYERS > LAYER_SLOTS) ? MAX_LAYERS : LAYER_SLOTS;
	localparam int CNT_W    = $clog2(CNT_MAX + 1);

	// Drain between the last slot read and the first chain cycle, covering the two
	// register stages behind the memory output that lead to the cell's hit flag.
	localparam int DRAIN_CYCLES = 2;

	// One input item: a rectangle in Q12.4.
	typedef struct packed {
		logic        [15:0] rect_height;
		logic        [15:0] rect_width;
		logic signed [15:0] center_y;
		logic signed [15:0] center_x;
	} ola_in_t;

	// One result item.
	typedef struct packed {
		logic       accepted;
		logic [3:0] layer_index;
		logic [3:0] slot_index;
		logic [4:0] layers_used;
	} ola_out_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                clear;
		logic                rd_en;
		logic [SLOT_AW-1:0]  rd_addr;
		logic                chain_en;
		logic                wr_en;
		logic [LAYER_AW-1:0] wr_layer;
	} ola_ctl_t;

endpackage

// ===== rtl/overlap_layer_assigner_core.sv =====
// Top level of the overlap layer assigner: sequencer plus a row of layer cells.
// Depends on ola_pkg and ola_cell.
//
// Each item is one rectangle (center and size in Q12.4). The block compares it
// against every stored rectangle, places it in the layer just above the highest
// layer holding an overlapping rectangle, and returns one result item per input
// item: accepted flag, layer, slot within the layer, and layers in use. An item
// is taken when start is high while busy is low. Then all layer cells scan their
// slots in parallel, one slot read per cycle from each cell's memory, then after
// a drain the verdict ripples through the chain of cells one cell per cycle, then
// the commit state stores the rectangle. busy drops in the same cycle that done
// rises, so the next item may be started while the result is shown. The result is
// held on the result port for exactly one cycle with done high and cannot be
// stalled; the receiver must take it then. A rejected item (no free layer, or its
// layer full) stores nothing and reports zero layer and slot.
module overlap_layer_assigner_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ola_pkg::ola_in_t  rect,
	output logic              done,
	output ola_pkg::ola_out_t result
);
	import ola_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_CHAIN  = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	ola_in_t           rect_q;
	logic [NEED_W-1:0] total_q;
	logic              done_q;
	ola_out_t          result_q;
	ola_ctl_t          ctl;

	// Chain wiring: need_chain[i] enters cell i, need_chain[i+1] leaves it.
	logic [NEED_W-1:0] need_chain [MAX_LAYERS+1];
	logic [FILL_W-1:0] fills      [MAX_LAYERS];

	logic [NEED_W-1:0] needed;
	logic [FILL_W-1:0] fill_sel;
	logic              reject;
	logic [NEED_W-1:0] total_new;

	assign need_chain[0] = '0;

	genvar g;
	generate
		for (g = 0; g < MAX_LAYERS; g++) begin : g_cell
			ola_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.layer_id (LAYER_AW'(g)),
				.rect     (rect_q),
				.ctl      (ctl),
				.need_in  (need_chain[g]),
				.need_out (need_chain[g+1]),
				.fill     (fills[g])
			);
		end
	endgenerate

	// The last cell holds the final answer once the chain has settled.
	assign needed = need_chain[MAX_LAYERS];

	always_comb begin
		fill_sel = '0;
		if (needed < NEED_W'(MAX_LAYERS)) begin
			fill_sel = fills[needed[LAYER_AW-1:0]];
		end
	end

	// Either every layer is taken and another is needed, or the target layer is full.
	assign reject = (needed >= NEED_W'(MAX_LAYERS)) ||
	                ((needed < total_q) && (fill_sel >= FILL_W'(LAYER_SLOTS)));
	assign total_new = (needed >= total_q) ? (needed + NEED_W'(1)) : total_q;

	// Control broadcast to the cells.
	always_comb begin
		ctl          = '0;
		ctl.clear    = (state_q == ST_IDLE) && start;
		ctl.rd_en    = (state_q == ST_SCAN);
		ctl.rd_addr  = cnt_q[SLOT_AW-1:0];
		ctl.chain_en = (state_q == ST_CHAIN);
		ctl.wr_en    = (state_q == ST_COMMIT) && !reject;
		ctl.wr_layer = needed[LAYER_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			rect_q <= rect;
		end
		if (state_q == ST_COMMIT) begin
			if (reject) begin
				result_q.accepted    <= 1'b0;
				result_q.layer_index <= '0;
				result_q.slot_index  <= '0;
				result_q.layers_used <= 5'(total_q);
			end else begin
				result_q.accepted    <= 1'b1;
				result_q.layer_index <= 4'(needed);
				result_q.slot_index  <= 4'(fill_sel);
				result_q.layers_used <= 5'(total_new);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(LAYER_SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == CNT_W'(DRAIN_CYCLES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_CHAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_CHAIN: begin
					if (cnt_q == CNT_W'(MAX_LAYERS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_COMMIT: begin
					if (!reject) begin
						total_q <= total_new;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/ola_cell.sv =====
// One layer cell: holds the rectangles of one layer, scans them against the
// new rectangle and passes the layer just above the highest overlapping one on to its neighbor.
// Depends on ola_pkg.
module ola_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ola_pkg::LAYER_AW-1:0] layer_id,
	input  ola_pkg::ola_in_t             rect,
	input  ola_pkg::ola_ctl_t            ctl,
	input  logic [ola_pkg::NEED_W-1:0]   need_in,
	output logic [ola_pkg::NEED_W-1:0]   need_out,
	output logic [ola_pkg::FILL_W-1:0]   fill
);
	import ola_pkg::*;

	ola_in_t             mem [LAYER_SLOTS];
	ola_in_t             data_s1;
	logic                v_s1;
	logic        [15:0]  adx_s2;
	logic        [15:0]  ady_s2;
	logic        [16:0]  sw_s2;
	logic        [16:0]  sh_s2;
	logic                v_s2;
	logic                hit_q;
	logic [NEED_W-1:0]   need_q;
	logic [FILL_W-1:0]   fill_q;
	logic signed [16:0]  dx;
	logic signed [16:0]  dy;
	logic                wr_here;
	logic                overlap;

	assign wr_here = ctl.wr_en && (ctl.wr_layer == layer_id);

	// Slot storage: written on commit, read during the scan.
	always_ff @(posedge clk) begin
		if (wr_here) begin
			mem[fill_q[SLOT_AW-1:0]] <= rect;
		end
		data_s1 <= mem[ctl.rd_addr];
	end

	// Differences and size sums for the overlap test.
	assign dx = 17'(rect.center_x) - 17'(data_s1.center_x);
	assign dy = 17'(rect.center_y) - 17'(data_s1.center_y);

	always_ff @(posedge clk) begin
		adx_s2 <= dx[16] ? 16'(-dx) : 16'(dx);
		ady_s2 <= dy[16] ? 16'(-dy) : 16'(dy);
		sw_s2  <= 17'(rect.rect_width) + 17'(data_s1.rect_width);
		sh_s2  <= 17'(rect.rect_height) + 17'(data_s1.rect_height);
	end

	assign overlap = ({adx_s2, 1'b0} < sw_s2) && ({ady_s2, 1'b0} < sh_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			hit_q  <= 1'b0;
			need_q <= '0;
			fill_q <= '0;
		end else begin
			v_s1 <= ctl.rd_en && (FILL_W'(ctl.rd_addr) < fill_q);
			v_s2 <= v_s1;
			if (ctl.clear) begin
				hit_q <= 1'b0;
			end else if (v_s2 && overlap) begin
				hit_q <= 1'b1;
			end
			// A hit here overrides whatever lower layers reported.
			if (ctl.chain_en) begin
				need_q <= hit_q ? (NEED_W'(layer_id) + NEED_W'(1)) : need_in;
			end
			if (wr_here) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign need_out = need_q;
	assign fill     = fill_q;

endmodule

// ===== rtl/ola_checker.sv =====
// Port-level checks for the overlap layer assigner, bound to its top level.
// Depends on ola_pkg and overlap_layer_assigner_core.
module ola_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ola_pkg::ola_out_t result
);
	import ola_pkg::*;

	// An accepted item always makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken but block not busy");

	// A result is shown only once the block has finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Finishing an item always yields exactly one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A rejected item reports neither a layer nor a slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted) |->
			(result.layer_index == 4'd0) && (result.slot_index == 4'd0))
		else $error("rejected item with nonzero layer or slot");

endmodule

bind overlap_layer_assigner_core ola_checker u_ola_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for overlap_layer_assigner_core: rectangles in, layer assignments out.
// Depends on ola_pkg and the block's RTL; holds its own layer placement tracker.
module tb_top;
	import ola_pkg::*;

	// Quiet cycles the watchdog tolerates: the longest sender gap plus one full item
	// of the block, with a wide margin.
	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 900;
	localparam int TAIL_CYCLES  = 2 * (LAYER_SLOTS + MAX_LAYERS + 3);

	// Mirrors the block's layer table: every stored rectangle, the fill of each layer
	// and the number of open layers. Each accepted item yields one expected result,
	// and results must come back in the order the items went in.
	class layer_tracker;
		ola_in_t  placed [MAX_LAYERS][LAYER_SLOTS];
		int       fill [MAX_LAYERS];
		int       layers_open;
		ola_out_t pending_placements [$];
		int       mismatch_count;
		int       items_seen;
		int       results_seen;
		int       stored_count;
		int       full_layer_rejects;
		int       no_layer_rejects;
		int       peak_layers;

		function new();
			foreach (fill[i])
				fill[i] = 0;
			layers_open        = 0;
			mismatch_count     = 0;
			items_seen         = 0;
			results_seen       = 0;
			stored_count       = 0;
			full_layer_rejects = 0;
			no_layer_rejects   = 0;
			peak_layers        = 0;
		endfunction

		// Exact integer overlap test on the raw Q12.4 codes. Both comparisons are
		// strict, so rectangles that only touch do not overlap.
		function bit rects_overlap(ola_in_t a, ola_in_t b);
			int dx;
			int dy;
			int sum_w;
			int sum_h;
			dx    = int'($signed(a.center_x)) - int'($signed(b.center_x));
			dy    = int'($signed(a.center_y)) - int'($signed(b.center_y));
			sum_w = int'($unsigned(a.rect_width)) + int'($unsigned(b.rect_width));
			sum_h = int'($unsigned(a.rect_height)) + int'($unsigned(b.rect_height));
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			return (2 * dx < sum_w) && (2 * dy < sum_h);
		endfunction

		// Called for every accepted item: find the layer above the highest layer
		// holding an overlapping rectangle, then store or reject.
		function void place_rect(ola_in_t r);
			int       needed;
			ola_out_t want;
			needed = 0;
			items_seen++;
			for (int i = 0; i < layers_open; i++)
				for (int j = 0; j < fill[i]; j++)
					if (rects_overlap(placed[i][j], r))
						needed = i + 1;
			want = '0;
			if (needed >= MAX_LAYERS) begin
				no_layer_rejects++;
				want.layers_used = 5'(layers_open);
			end else if (needed < layers_open && fill[needed] >= LAYER_SLOTS) begin
				full_layer_rejects++;
				want.layers_used = 5'(layers_open);
			end else begin
				if (needed >= layers_open) begin
					fill[needed] = 0;
					layers_open  = needed + 1;
				end
				placed[needed][fill[needed]] = r;
				want.accepted    = 1'b1;
				want.layer_index = 4'(needed);
				want.slot_index  = 4'(fill[needed]);
				want.layers_used = 5'(layers_open);
				fill[needed]++;
				stored_count++;
				if (layers_open > peak_layers)
					peak_layers = layers_open;
			end
			pending_placements.push_back(want);
		endfunction

		// Called for every result strobe: compare against the oldest expectation.
		function void match_result(ola_out_t got);
			ola_out_t want;
			if (pending_placements.size() == 0) begin
				$error("result with no item outstanding: %s=%0d layer=%0d slot=%0d used=%0d",
					"accepted", got.accepted, got.layer_index, got.slot_index,
					got.layers_used);
				mismatch_count++;
				return;
			end
			want = pending_placements.pop_front();
			results_seen++;
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				mismatch_count++;
			end
			if (got.layer_index !== want.layer_index) begin
				$error("layer_index: expected %0d, got %0d",
					want.layer_index, got.layer_index);
				mismatch_count++;
			end
			if (got.slot_index !== want.slot_index) begin
				$error("slot_index: expected %0d, got %0d",
					want.slot_index, got.slot_index);
				mismatch_count++;
			end
			if (got.layers_used !== want.layers_used) begin
				$error("layers_used: expected %0d, got %0d",
					want.layers_used, got.layers_used);
				mismatch_count++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ola_in_t  rect;
	logic     done;
	ola_out_t result;

	layer_tracker tracker;
	int           quiet_cycles = 0;
	logic [15:0]  stack_x;
	logic [15:0]  stack_y;
	bit           steady_run;

	overlap_layer_assigner_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.rect   (rect),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sender gap before the next item. Most gaps are short, a few are long enough to
	// let the block go idle, and during a steady run there are none at all. Since the
	// gap counts from the previous acceptance, start rises early in, late in or after busy.
	function int pick_gap();
		int roll;
		if (steady_run)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 2);
		if (roll < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function logic [15:0] edge_code(bit is_size);
		case ($urandom_range(0, 4))
			0: return is_size ? 16'h0000 : 16'h8000;
			1: return is_size ? 16'h0001 : 16'hFFFF;
			2: return 16'h0000;
			3: return is_size ? 16'hFFFE : 16'h0001;
			default: return is_size ? 16'hFFFF : 16'h7FFF;
		endcase
	endfunction

	// Random rectangles come in several families. A tight cluster and repeated
	// centers make rectangles pile up into many layers, which is what reaches the
	// layer count limit; tiny scattered ones mostly land in layer 0 and fill it.
	// Raw random codes and edge codes cover every bit and the extremes of each field.
	function ola_in_t random_rect();
		ola_in_t r;
		int      roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			r.center_x    = 16'($urandom_range(0, 4095) - 2048);
			r.center_y    = 16'($urandom_range(0, 4095) - 2048);
			r.rect_width  = 16'($urandom_range(0, 1024));
			r.rect_height = 16'($urandom_range(0, 1024));
		end else if (roll < 60) begin
			r.center_x    = stack_x + 16'($urandom_range(0, 64) - 32);
			r.center_y    = stack_y + 16'($urandom_range(0, 64) - 32);
			r.rect_width  = 16'($urandom_range(0, 4096));
			r.rect_height = 16'($urandom_range(0, 4096));
			if ($urandom_range(0, 7) == 0) begin
				stack_x = 16'($urandom);
				stack_y = 16'($urandom);
			end
		end else if (roll < 75) begin
			r.center_x    = 16'($urandom);
			r.center_y    = 16'($urandom);
			r.rect_width  = 16'($urandom_range(0, 15));
			r.rect_height = 16'($urandom_range(0, 15));
		end else if (roll < 90) begin
			r = ola_in_t'({$urandom, $urandom});
		end else begin
			r.center_x    = edge_code(1'b0);
			r.center_y    = edge_code(1'b0);
			r.rect_width  = edge_code(1'b1);
			r.rect_height = edge_code(1'b1);
		end
		return r;
	endfunction

	// Offer one item after the given gap and hold it until the block takes it. start
	// stays high across back-to-back items; it is only lowered for a gap or a drain, so
	// each signal sees at most one assignment per falling edge. While idle the rect
	// bus carries noise that the block must ignore.
	task automatic send_rect(ola_in_t r, int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			rect  <= ola_in_t'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		rect  <= r;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		tracker.place_rect(r);
	endtask

	task automatic send_directed(int cx, int cy, int w, int h);
		ola_in_t r;
		r.center_x    = 16'(cx);
		r.center_y    = 16'(cy);
		r.rect_width  = 16'(w);
		r.rect_height = 16'(h);
		send_rect(r, pick_gap());
	endtask

	// Drop start and hold off until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending_placements.size() != 0)
			@(posedge clk);
	endtask

	// Results cannot be stalled, so every strobe is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.match_result(result);
	end

	// Watchdog: a run that stops moving for too long has hung.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("overlap_layer_assigner_core regression: fail");
			$finish;
		end
	end

	initial begin
		tracker      = new();
		steady_run   = 1'b0;
		stack_x      = 16'h1000;
		stack_y      = 16'hF000;
		start        = 1'b0;
		rect         = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty rectangles at one center never overlap each other, so both land in
		// layer 0.
		send_directed(0, 0, 0, 0);
		send_directed(0, 0, 0, 0);
		// Extreme centers with extreme sizes; the two opposite corners sit exactly
		// one full span apart and only touch.
		send_directed(32767, 32767, 65535, 65535);
		send_directed(-32768, -32768, 65535, 65535);
		send_directed(-32768, 32767, 1, 1);
		send_directed(32767, -32768, 0, 65535);
		// Touching edges do not overlap; one code closer does.
		send_directed(-20000, -20000, 160, 160);
		send_directed(-19840, -20000, 160, 160);
		send_directed(-19841, -20000, 160, 160);
		// Apart in y only, then a zero-width sliver inside an existing rectangle.
		send_directed(-20000, -19000, 160, 160);
		send_directed(-20000, -20000, 0, 40);
		// The same rectangle again and again climbs one layer each time.
		repeat (6) send_directed(10000, -10000, 800, 800);
		// Negative offsets on both axes.
		send_directed(9700, -10300, 800, 800);

		// Random part. Steady runs without gaps come and go, and twice the sender
		// stops until the block has answered everything.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				steady_run = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3)
				drain_results();
			send_rect(random_rect(), pick_gap());
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.pending_placements.size() != 0) begin
			$error("%0d results never arrived", tracker.pending_placements.size());
			tracker.mismatch_count++;
		end
		$display("Sent %0d rectangles: %0d stored in up to %0d layers,",
			tracker.items_seen, tracker.stored_count, tracker.peak_layers);
		$display("%0d refused for a full layer, %0d refused with no layer left.",
			tracker.full_layer_rejects, tracker.no_layer_rejects);
		$display("Checked %0d results field by field; %0d mismatches.",
			tracker.results_seen, tracker.mismatch_count);
		if (tracker.mismatch_count == 0)
			$display("overlap_layer_assigner_core regression: pass");
		else
			$display("overlap_layer_assigner_core regression: fail");
		$finish;
	end
endmodule
